/* hw/rtl/ppc_pkg.sv */
package ppc_pkg;

  // Input transaction kinds
  typedef enum logic [2:0] {
    KIND_READ_DATA     = 3'd0,
    KIND_READ_STATUS   = 3'd1,
    KIND_READ_CONTROL  = 3'd2,
    KIND_WRITE_DATA    = 3'd3,
    KIND_WRITE_CONTROL = 3'd4,
    KIND_WRITE_SELECT  = 3'd5,
    KIND_TICK          = 3'd6
  } kind_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ADD_LINE_FEED = 2'd0,
    CFG_ADD_FORM_FEED = 2'd1,
    CFG_IDLE_TIMEOUT  = 2'd2
  } cfg_idx_e;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned IdleW     = 17;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned CountW    = 3;
  localparam int unsigned MaxNew    = 3;

  localparam logic [7:0]       StatusBase   = 8'h9f;
  localparam logic [7:0]       StatusNoAck  = 8'h40;
  localparam logic [7:0]       CharCr       = 8'h0d;
  localparam logic [7:0]       CharLf       = 8'h0a;
  localparam logic [7:0]       CharFf       = 8'd12;
  localparam logic [15:0]      TimeoutReset = 16'd500;
  localparam logic [IdleW-1:0] IdleMax      = {IdleW{1'b1}};
  localparam int unsigned      StrobeBit    = 0;
  localparam int unsigned      AutofeedBit  = 1;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       print_valid;
    logic [7:0] print_byte;
    logic       last;
  } out_t;

endpackage

/* hw/rtl/parallel_printer_port_capture_unit.sv */
// Parallel printer port capture. Each input transaction (register read or
// write, or a millisecond tick) is accepted and its results, zero to three,
// are placed at once into a four-entry output queue that drains one result
// per cycle while out_stall_i is low. A new transaction is taken in every
// cycle as long as at most one result is left queued; a strobe that prints
// three bytes therefore holds the output longer, and the output queue drain
// sets the sustained rate. Configuration writes take effect at the next edge.
module parallel_printer_port_capture_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  ppc_pkg::in_t           in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output ppc_pkg::out_t          out_data_o,
  input  logic                   cfg_we_i,
  input  logic [ppc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ppc_pkg::CfgDataW-1:0] cfg_data_i
);
  import ppc_pkg::*;

  // Configuration
  logic        add_lf_q;
  logic        add_ff_q;
  logic [15:0] timeout_q;

  // Port state
  logic [7:0]       data_q, data_d;
  logic             strobe_q, strobe_d;
  logic             ack_q, ack_d;
  logic [7:0]       prev_q, prev_d;
  logic             job_q, job_d;
  logic [IdleW-1:0] idle_q, idle_d;

  // Output queue
  out_t              queue_q [QueueDepth];
  out_t              queue_d [QueueDepth];
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] base;

  out_t       new_res [MaxNew];
  logic [1:0] new_cnt;

  logic             accept, pop, strobe_edge, extra_lf, auto_lf, close_job;
  logic [IdleW-1:0] idle_inc;

  assign pop         = (count_q != '0) && !out_stall_i;
  assign base        = count_q - CountW'(pop);
  assign in_stall_o  = (base > CountW'(1));
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = queue_q[0];

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_lf_q  <= 1'b0;
      add_ff_q  <= 1'b0;
      timeout_q <= TimeoutReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ADD_LINE_FEED: add_lf_q  <= cfg_data_i[0];
        CFG_ADD_FORM_FEED: add_ff_q  <= cfg_data_i[0];
        CFG_IDLE_TIMEOUT:  timeout_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Strobe printing and idle timer terms
  assign strobe_edge = (in_data_i.kind == KIND_WRITE_CONTROL) &&
                       !in_data_i.value[StrobeBit] && strobe_q;
  assign extra_lf    = add_lf_q && (prev_q == CharCr) && (data_q != CharLf);
  assign auto_lf     = in_data_i.value[AutofeedBit] && (data_q == CharCr);
  assign idle_inc    = (idle_q == IdleMax) ? idle_q : idle_q + IdleW'(1);
  assign close_job   = (timeout_q != '0) && (idle_inc > {1'b0, timeout_q});

  // Decode the transaction: state update and new results
  always_comb begin
    data_d   = data_q;
    strobe_d = strobe_q;
    ack_d    = ack_q;
    prev_d   = prev_q;
    job_d    = job_q;
    idle_d   = idle_q;
    new_cnt  = 2'd0;
    for (int j = 0; j < MaxNew; j++) begin
      new_res[j] = '0;
    end

    unique case (in_data_i.kind)
      KIND_READ_DATA: begin
        new_res[0].read_value = data_q;
        new_cnt               = 2'd1;
      end
      KIND_READ_STATUS: begin
        new_res[0].read_value = ack_q ? StatusBase : (StatusBase | StatusNoAck);
        new_cnt               = 2'd1;
        ack_d                 = 1'b0;
      end
      KIND_READ_CONTROL: begin
        new_cnt = 2'd1;
      end
      KIND_WRITE_DATA: begin
        data_d = in_data_i.value;
      end
      KIND_WRITE_CONTROL: begin
        strobe_d = in_data_i.value[StrobeBit];
        if (strobe_edge) begin
          // Data byte, then a line feed from either source; both are LF
          new_res[0].print_valid = 1'b1;
          new_res[0].print_byte  = data_q;
          new_res[1].print_valid = 1'b1;
          new_res[1].print_byte  = CharLf;
          new_res[2].print_valid = 1'b1;
          new_res[2].print_byte  = CharLf;
          new_cnt = 2'd1 + 2'(extra_lf) + 2'(auto_lf);
          ack_d   = 1'b1;
          job_d   = 1'b1;
          idle_d  = '0;
          if (add_lf_q) begin
            prev_d = auto_lf ? CharLf : data_q;
          end
        end
      end
      KIND_TICK: begin
        if (job_q) begin
          idle_d = idle_inc;
          if (close_job) begin
            job_d  = 1'b0;
            prev_d = '0;
            if (add_ff_q) begin
              new_res[0].print_valid = 1'b1;
              new_res[0].print_byte  = CharFf;
              new_cnt                = 2'd1;
            end
          end
        end
      end
      default: ;
    endcase

    // Flag the final result of this transaction
    for (int j = 0; j < MaxNew; j++) begin
      new_res[j].last = (2'(j + 1) == new_cnt);
    end
  end

  // Shift out the taken result and append new ones behind what is left
  always_comb begin
    for (int i = 0; i < QueueDepth; i++) begin
      if (pop && (i < QueueDepth - 1)) begin
        queue_d[i] = queue_q[(i + 1) % QueueDepth];
      end else begin
        queue_d[i] = queue_q[i];
      end
      for (int j = 0; j < MaxNew; j++) begin
        if (accept && (2'(j) < new_cnt) && (CountW'(i) == base + CountW'(j))) begin
          queue_d[i] = new_res[j];
        end
      end
    end
    count_d = base + (accept ? CountW'(new_cnt) : '0);
  end

  // Hold queue payload
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QueueDepth; i++) begin
      queue_q[i] <= queue_d[i];
    end
  end

  // Advance port state on accepted transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      data_q   <= '0;
      strobe_q <= 1'b0;
      ack_q    <= 1'b0;
      prev_q   <= '0;
      job_q    <= 1'b0;
      idle_q   <= '0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        data_q   <= data_d;
        strobe_q <= strobe_d;
        ack_q    <= ack_d;
        prev_q   <= prev_d;
        job_q    <= job_d;
        idle_q   <= idle_d;
      end
    end
  end

endmodule

/* hw/rtl/ppc_checker.sv */
module ppc_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input ppc_pkg::in_t           in_data_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input ppc_pkg::out_t          out_data_o
);
  import ppc_pkg::*;

  // A stalled result transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Input is only stalled while results are queued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // An accepted register read yields a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (in_data_i.kind == KIND_READ_DATA || in_data_i.kind == KIND_READ_STATUS ||
     in_data_i.kind == KIND_READ_CONTROL) |=> out_valid_o)
    else $error("read result missing");

  // A non-print result is a single, final read result with no byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.print_valid |->
      out_data_o.last && (out_data_o.print_byte == '0))
    else $error("malformed read result");

endmodule

bind parallel_printer_port_capture_unit ppc_checker u_ppc_checker (.*);
